/* rtl/sec_pkg.sv */
// Shared types and constants for the SIEVE-replaced key table.
// Used by sec_out_reg, sieve_endpoint_cache_unit and the testbench; depends on nothing else.
package sec_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic        report_kind;
        logic        found;
        logic [5:0]  slot;
        logic [31:0] evicted_key;
        logic [6:0]  entry_count;
        logic        last;
    } t_out_item;

endpackage

/* rtl/sec_out_reg.sv */
// Single-entry output register for result items with a valid/ready handshake.
// Depends on sec_pkg for the result item type.
module sec_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sec_pkg::t_out_item i_data,
    output logic               o_can_load,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sec_pkg::t_out_item o_out_data
);
    import sec_pkg::*;

    logic      r_full;
    t_out_item r_data;

    // The slot may be refilled in the same cycle as its transfer completes.
    assign o_can_load  = !r_full || i_out_ready;
    assign o_out_valid = r_full;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_out_ready) begin
            r_full <= 1'b0;
        end
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

/* rtl/sieve_endpoint_cache_unit.sv */
// Top level of the SIEVE-replaced key table: sequencer, key and link memories.
// Depends on sec_pkg and sec_out_reg.

// One item is handled at a time. Every item other than the unused opcode
// first scans the key memory one slot per cycle. An insert that must evict
// then, per victim, steps the hand past each visited entry and checks,
// unlinks and reports the victim, waiting on the output if it stalls; placing
// the new key then scans the valid bits one slot per cycle until a free slot
// is found. The single read port of the key memory sets the search time.
// No clearing pass is needed after reset.
module sieve_endpoint_cache_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sec_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sec_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_wdata
);
    import sec_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_SEARCH_END, S_DISPATCH, S_DEL_RD, S_DEL_UNL,
        S_INS_CHK, S_EV_CHK, S_EV_STEP, S_EV_UNL, S_EV_OUT, S_FREE,
        S_INS_WR, S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [CAPACITY-1:0]   r_valid, n_valid;
    logic [CAPACITY-1:0]   r_visited, n_visited;
    logic [SLOT_BITS-1:0]  r_newest, n_newest;
    logic [SLOT_BITS-1:0]  r_oldest, n_oldest;
    logic [SLOT_BITS-1:0]  r_hand, n_hand;
    logic                  r_hand_set, n_hand_set;
    logic [CNT_BITS-1:0]   r_occ, n_occ;
    logic [6:0]            r_max, n_max;
    logic [1:0]            r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [SLOT_BITS-1:0]  r_idx, n_idx;
    logic [SLOT_BITS-1:0]  r_cmp_slot, n_cmp_slot;
    logic                  r_cmp_v, n_cmp_v;
    logic                  r_hit, n_hit;
    logic [SLOT_BITS-1:0]  r_hit_slot, n_hit_slot;
    logic [SLOT_BITS-1:0]  r_o, n_o;
    logic [5:0]            r_k, n_k;
    logic [KEY_BITS-1:0]   r_ev_key, n_ev_key;
    logic                  r_fin_found, n_fin_found;
    logic [SLOT_BITS-1:0]  r_fin_slot, n_fin_slot;

    logic [KEY_BITS-1:0]   r_key_mem [CAPACITY];
    logic [SLOT_BITS-1:0]  r_newer_mem [CAPACITY];
    logic [SLOT_BITS-1:0]  r_older_mem [CAPACITY];
    logic [KEY_BITS-1:0]   r_key_rd;
    logic [SLOT_BITS-1:0]  r_newer_rd;
    logic [SLOT_BITS-1:0]  r_older_rd;

    logic                  w_key_we;
    logic [SLOT_BITS-1:0]  w_key_raddr;
    logic                  w_nl_we, w_ol_we;
    logic [SLOT_BITS-1:0]  w_nl_waddr, w_nl_wdata, w_ol_waddr, w_ol_wdata;
    logic [CNT_BITS-1:0]   w_lim;
    logic                  w_load, w_can_load;
    t_out_item             w_out;

    sec_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_data      (w_out),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_key_raddr = (r_state == S_SEARCH) ? r_idx : r_o;

    always_comb begin
        if (r_max == 7'd0) begin
            w_lim = CNT_BITS'(1);
        end else if (r_max > 7'(CAPACITY)) begin
            w_lim = CNT_BITS'(CAPACITY);
        end else begin
            w_lim = CNT_BITS'(r_max);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_visited   = r_visited;
        n_newest    = r_newest;
        n_oldest    = r_oldest;
        n_hand      = r_hand;
        n_hand_set  = r_hand_set;
        n_occ       = r_occ;
        n_max       = i_cfg_we ? i_cfg_wdata : r_max;
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_cmp_slot  = r_cmp_slot;
        n_cmp_v     = r_cmp_v;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_o         = r_o;
        n_k         = r_k;
        n_ev_key    = r_ev_key;
        n_fin_found = r_fin_found;
        n_fin_slot  = r_fin_slot;
        w_key_we    = 1'b0;
        w_nl_we     = 1'b0;
        w_ol_we     = 1'b0;
        w_nl_waddr  = r_o;
        w_nl_wdata  = r_o;
        w_ol_waddr  = r_o;
        w_ol_wdata  = r_o;
        w_load      = 1'b0;
        w_out       = '0;

        // Compare the key read in the previous cycle.
        if ((r_state == S_SEARCH || r_state == S_SEARCH_END) && r_cmp_v &&
            r_valid[r_cmp_slot] && r_key_rd == r_key && !r_hit) begin
            n_hit      = 1'b1;
            n_hit_slot = r_cmp_slot;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = i_in_data.opcode;
                    n_key       = i_in_data.key;
                    n_idx       = '0;
                    n_cmp_v     = 1'b0;
                    n_hit       = 1'b0;
                    n_hit_slot  = '0;
                    n_fin_found = 1'b0;
                    n_fin_slot  = '0;
                    if (i_in_data.opcode inside {OP_LOOKUP, OP_INSERT, OP_DELETE}) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SEARCH: begin
                n_cmp_slot = r_idx;
                n_cmp_v    = 1'b1;
                n_idx      = r_idx + 1'b1;
                if (r_idx == SLOT_BITS'(CAPACITY - 1)) begin
                    n_state = S_SEARCH_END;
                end
            end
            S_SEARCH_END: begin
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_fin_found = r_hit;
                n_fin_slot  = r_hit ? r_hit_slot : '0;
                n_o         = r_hit_slot;
                n_state     = S_FIN;
                if (r_op == OP_LOOKUP) begin
                    if (r_hit) begin
                        n_visited[r_hit_slot] = 1'b1;
                    end
                end else if (r_op == OP_DELETE) begin
                    if (r_hit) begin
                        n_state = S_DEL_RD;
                    end
                end else if (!r_hit) begin
                    n_k     = '0;
                    n_state = S_INS_CHK;
                end
            end
            S_DEL_RD: begin
                n_state = S_DEL_UNL;
            end
            S_INS_CHK: begin
                if (r_occ >= w_lim && r_occ != '0 && r_k != 6'd63) begin
                    n_o     = (r_hand_set && r_valid[r_hand]) ? r_hand : r_oldest;
                    n_state = S_EV_CHK;
                end else begin
                    n_idx   = '0;
                    n_state = S_FREE;
                end
            end
            S_EV_CHK: begin
                if (r_visited[r_o]) begin
                    n_visited[r_o] = 1'b0;
                    if (r_o == r_newest) begin
                        n_o = r_oldest;
                    end else begin
                        n_state = S_EV_STEP;
                    end
                end else begin
                    n_state = S_EV_UNL;
                end
            end
            S_EV_STEP: begin
                n_o     = r_newer_rd;
                n_state = S_EV_CHK;
            end
            S_EV_OUT: begin
                if (w_can_load) begin
                    w_load            = 1'b1;
                    w_out.report_kind = KIND_EVICT;
                    w_out.slot        = 6'(r_o);
                    w_out.evicted_key = 32'(r_ev_key);
                    w_out.entry_count = 7'(r_occ);
                    n_k               = r_k + 1'b1;
                    n_state           = S_INS_CHK;
                end
            end
            S_FREE: begin
                if (!r_valid[r_idx]) begin
                    n_o     = r_idx;
                    n_state = S_INS_WR;
                end else if (r_idx == SLOT_BITS'(CAPACITY - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_INS_WR: begin
                w_key_we       = 1'b1;
                n_valid[r_o]   = 1'b1;
                n_visited[r_o] = 1'b0;
                if (r_occ == '0) begin
                    n_oldest = r_o;
                end else begin
                    w_nl_we    = 1'b1;
                    w_nl_waddr = r_newest;
                    w_nl_wdata = r_o;
                    w_ol_we    = 1'b1;
                    w_ol_waddr = r_o;
                    w_ol_wdata = r_newest;
                end
                n_newest   = r_o;
                n_occ      = r_occ + 1'b1;
                n_fin_slot = r_o;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (w_can_load) begin
                    w_load            = 1'b1;
                    w_out.report_kind = KIND_FINAL;
                    w_out.found       = r_fin_found;
                    w_out.slot        = 6'(r_fin_slot);
                    w_out.entry_count = 7'(r_occ);
                    w_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        // Hand movement and unlinking of r_o, shared by delete and eviction.
        if (r_state == S_EV_UNL || r_state == S_DEL_UNL) begin
            if (r_state == S_EV_UNL) begin
                n_ev_key = r_key_rd;
                n_state  = S_EV_OUT;
                if (r_occ <= CNT_BITS'(1)) begin
                    n_hand_set = 1'b0;
                end else begin
                    n_hand     = (r_o == r_newest) ? r_oldest : r_newer_rd;
                    n_hand_set = 1'b1;
                end
            end else begin
                n_state = S_FIN;
                if (r_hand_set && r_hand == r_o) begin
                    if (r_o == r_newest) begin
                        n_hand_set = 1'b0;
                    end else begin
                        n_hand = r_newer_rd;
                    end
                end
            end
            if (r_o == r_newest && r_o == r_oldest) begin
                n_newest = r_newest;
            end else if (r_o == r_newest) begin
                n_newest = r_older_rd;
            end else if (r_o == r_oldest) begin
                n_oldest = r_newer_rd;
            end else begin
                w_nl_we    = 1'b1;
                w_nl_waddr = r_older_rd;
                w_nl_wdata = r_newer_rd;
                w_ol_we    = 1'b1;
                w_ol_waddr = r_newer_rd;
                w_ol_wdata = r_older_rd;
            end
            n_valid[r_o]   = 1'b0;
            n_visited[r_o] = 1'b0;
            if (r_occ != '0) begin
                n_occ = r_occ - 1'b1;
            end
            if (r_occ <= CNT_BITS'(1)) begin
                n_hand_set = 1'b0;
                n_newest   = '0;
                n_oldest   = '0;
                n_hand     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_visited  <= '0;
            r_newest   <= '0;
            r_oldest   <= '0;
            r_hand     <= '0;
            r_hand_set <= 1'b0;
            r_occ      <= '0;
            r_max      <= 7'(CAPACITY);
            r_cmp_v    <= 1'b0;
            r_hit      <= 1'b0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_visited  <= n_visited;
            r_newest   <= n_newest;
            r_oldest   <= n_oldest;
            r_hand     <= n_hand;
            r_hand_set <= n_hand_set;
            r_occ      <= n_occ;
            r_max      <= n_max;
            r_cmp_v    <= n_cmp_v;
            r_hit      <= n_hit;
            r_k        <= n_k;
        end
        r_op        <= n_op;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_cmp_slot  <= n_cmp_slot;
        r_hit_slot  <= n_hit_slot;
        r_o         <= n_o;
        r_ev_key    <= n_ev_key;
        r_fin_found <= n_fin_found;
        r_fin_slot  <= n_fin_slot;
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[r_o] <= r_key;
        end
        r_key_rd <= r_key_mem[w_key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_nl_we) begin
            r_newer_mem[w_nl_waddr] <= w_nl_wdata;
        end
        r_newer_rd <= r_newer_mem[r_o];
    end

    always_ff @(posedge i_clk) begin
        if (w_ol_we) begin
            r_older_mem[w_ol_waddr] <= w_ol_wdata;
        end
        r_older_rd <= r_older_mem[r_o];
    end

endmodule

/* dv/tb.sv */
// Self-checking testbench for sieve_endpoint_cache_unit: drives transfers of all
// four opcodes, predicts each result with a SIEVE key-table model and compares.
// Depends on sec_pkg and the RTL of sieve_endpoint_cache_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sec_pkg::*;

    localparam int SLOTS = 64;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_data;
    logic       i_cfg_we;
    logic [6:0] i_cfg_wdata;

    sieve_endpoint_cache_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // Predictor state.
    logic [31:0] tbl_key [SLOTS];
    logic        tbl_valid [SLOTS];
    logic        tbl_seen [SLOTS];
    logic [5:0]  link_newer [SLOTS];
    logic [5:0]  link_older [SLOTS];
    logic [5:0]  newest, oldest, hand;
    logic        hand_on;
    int          fill;
    logic [6:0]  limit_reg;

    t_out_item   expected_q[$];
    int          errors;
    int          mismatches;
    int          stall_left;
    bit          quiet_mode;
    bit          out_idle_en;
    logic [31:0] known_keys[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("sieve_endpoint_cache_unit: mismatch");
        $finish;
    end

    function automatic t_out_item make_res(logic kind, logic fnd, logic [5:0] s,
                                           logic [31:0] ek, logic lst);
        t_out_item r;
        r.report_kind = kind;
        r.found       = fnd;
        r.slot        = s;
        r.evicted_key = ek;
        r.entry_count = 7'(fill);
        r.last        = lst;
        return r;
    endfunction

    function automatic void expect_res(t_out_item r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void cache_unlink(logic [5:0] s);
        if (s == newest && s == oldest) begin
        end else if (s == newest) begin
            newest = link_older[s];
        end else if (s == oldest) begin
            oldest = link_newer[s];
        end else begin
            link_newer[link_older[s]] = link_newer[s];
            link_older[link_newer[s]] = link_older[s];
        end
        tbl_valid[s] = 1'b0;
        tbl_seen[s]  = 1'b0;
        if (fill > 0) fill--;
        if (fill == 0) begin
            hand_on = 1'b0;
            newest  = '0;
            oldest  = '0;
            hand    = '0;
        end
    endfunction

    function automatic logic [5:0] next_newer(logic [5:0] o);
        return (o == newest) ? oldest : link_newer[o];
    endfunction

    // Applies one item to the model and queues the results it should give.
    function automatic void cache_predict(t_in_item it);
        int          hit;
        int          n;
        int          lim;
        int          s;
        logic [5:0]  o;
        logic [31:0] vk;
        hit = -1;
        if (it.opcode == OP_UNUSED) begin
            expect_res(make_res(KIND_FINAL, 1'b0, 6'd0, 32'd0, 1'b1));
            return;
        end
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == it.key) hit = i;
        if (it.opcode == OP_LOOKUP) begin
            if (hit >= 0) tbl_seen[hit] = 1'b1;
            expect_res(make_res(KIND_FINAL, hit >= 0, (hit >= 0) ? 6'(hit) : 6'd0,
                                32'd0, 1'b1));
            return;
        end
        if (it.opcode == OP_DELETE) begin
            if (hit >= 0) begin
                if (hand_on && hand == 6'(hit)) begin
                    if (6'(hit) == newest) hand_on = 1'b0;
                    else hand = link_newer[hit];
                end
                cache_unlink(6'(hit));
            end
            expect_res(make_res(KIND_FINAL, hit >= 0, (hit >= 0) ? 6'(hit) : 6'd0,
                                32'd0, 1'b1));
            return;
        end
        if (hit >= 0) begin
            expect_res(make_res(KIND_FINAL, 1'b1, 6'(hit), 32'd0, 1'b1));
            return;
        end
        lim = limit_reg;
        if (lim < 1) lim = 1;
        if (lim > SLOTS) lim = SLOTS;
        n = 0;
        while (fill >= lim && fill > 0 && n < 63) begin
            o = (hand_on && tbl_valid[hand]) ? hand : oldest;
            for (int w = 0; w <= SLOTS && tbl_seen[o]; w++) begin
                tbl_seen[o] = 1'b0;
                o = next_newer(o);
            end
            if (fill <= 1) hand_on = 1'b0;
            else begin
                hand    = next_newer(o);
                hand_on = 1'b1;
            end
            vk = tbl_key[o];
            cache_unlink(o);
            expect_res(make_res(KIND_EVICT, 1'b0, o, vk, 1'b0));
            n++;
        end
        s = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!tbl_valid[i]) s = i;
        if (s >= SLOTS) begin
            expect_res(make_res(KIND_FINAL, 1'b0, 6'd0, 32'd0, 1'b1));
            return;
        end
        tbl_key[s]   = it.key;
        tbl_valid[s] = 1'b1;
        tbl_seen[s]  = 1'b0;
        if (fill == 0) begin
            newest = 6'(s);
            oldest = 6'(s);
        end else begin
            link_newer[newest] = 6'(s);
            link_older[s]      = newest;
            newest             = 6'(s);
        end
        fill++;
        expect_res(make_res(KIND_FINAL, 1'b0, 6'(s), 32'd0, 1'b1));
    endfunction

    // Sends one transfer, with an optional random gap first.
    task automatic send_item(logic [1:0] op, logic [31:0] key);
        t_in_item it;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        it.opcode = op;
        it.key    = key;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cache_predict(it);
        if (op == OP_INSERT) known_keys.insert(known_keys.size(), key);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        // The queue empties only once the last final answer has been transferred.
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [6:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg = v;
    endtask

    function automatic logic [31:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return $urandom_range(0, 40);
    endfunction

    // Output side: random stalls while out_idle_en is set, and checking
    // against the expectation queue.
    initial begin
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result %p", o_out_data);
                end else if (o_out_data !== expected_q[0]) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("expected %p got %p", expected_q[0], o_out_data);
                    void'(expected_q.pop_front());
                end else begin
                    void'(expected_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_item(OP_LOOKUP, 32'h0);
        send_item(OP_DELETE, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 32'h1234_5678);
        send_item(OP_INSERT, 32'h0);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'hA5A5_5A5A);
        send_item(OP_DELETE, 32'h0);
        send_item(OP_DELETE, 32'h0);
        send_item(OP_LOOKUP, 32'h5A5A_A5A5);
        // With a limit of one each insert evicts every entry already held.
        write_limit(7'd1);
        send_item(OP_INSERT, 32'h11);
        send_item(OP_INSERT, 32'h22);
        // Zero acts as one.
        write_limit(7'd0);
        send_item(OP_INSERT, 32'h33);
        // Larger limit, then shrink it to force a deep overshoot.
        write_limit(7'd127);
        for (int i = 0; i < 8; i++) send_item(OP_INSERT, 32'h100 + i);
        send_item(OP_LOOKUP, 32'h100);
        send_item(OP_LOOKUP, 32'h102);
        write_limit(7'd2);
        send_item(OP_INSERT, 32'h200);
    endtask

    task automatic test_fill_to_capacity();
        write_limit(7'd64);
        for (int i = 0; i < 66; i++) begin
            if (i % 5 == 0) send_item(OP_LOOKUP, 32'h300 + i / 2);
            send_item(OP_INSERT, 32'h300 + i);
        end
    endtask

    task automatic test_random(int count, logic [6:0] lim);
        int r;
        logic [1:0] op;
        write_limit(lim);
        known_keys.delete();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 19);
            if (r < 8) op = OP_INSERT;
            else if (r < 14) op = OP_LOOKUP;
            else if (r < 19) op = OP_DELETE;
            else op = OP_UNUSED;
            if ($urandom_range(0, 15) == 0) send_item(op, $urandom());
            else send_item(op, pick_key());
            if (i == count / 2) wait_drained();
        end
    endtask

    initial begin
        errors      = 0;
        mismatches  = 0;
        quiet_mode  = 1'b0;
        out_idle_en = 1'b1;
        limit_reg   = 7'd64;
        fill        = 0;
        newest = '0; oldest = '0; hand = '0; hand_on = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_seen[i]  = 1'b0;
        end
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_to_capacity();
        test_random(50, 7'd5);
        test_random(35, 7'd12);
        quiet_mode  = 1'b1;
        out_idle_en = 1'b0;
        test_random(20, 7'd3);
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("sieve_endpoint_cache_unit: match");
        else
            $display("sieve_endpoint_cache_unit: mismatch");
        $finish;
    end
endmodule

/* filelist.f */
rtl/sec_pkg.sv
rtl/sec_out_reg.sv
rtl/sieve_endpoint_cache_unit.sv
dv/tb.sv
